// File: design/dram_address_to_rank_decoder_top_macros.svh
// Assertion macros shared by the rank decoder modules.
`ifndef DRAM_ADDRESS_TO_RANK_DECODER_TOP_MACROS_SVH
`define DRAM_ADDRESS_TO_RANK_DECODER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DARD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent, outside reset.
`define DARD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/dard_pkg.sv
// Types and constants of the DRAM address to rank decoder.
package dard_pkg;

    localparam int NUM_RANGES       = 8;
    localparam int NUM_NODES        = 8;
    localparam int NUM_CHIP_SELECTS = 8;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [1:0] KIND_DROP     = 2'd0;
    localparam logic [1:0] KIND_RANGE_WR = 2'd1;
    localparam logic [1:0] KIND_NODE_WR  = 2'd2;
    localparam logic [1:0] KIND_XLATE    = 2'd3;

    localparam logic CFG_SPARE_CHAN0 = 1'b0;
    localparam logic CFG_SPARE_CHAN1 = 1'b1;

    localparam logic [4:0] SLOT_HOLE  = 5'd0;
    localparam logic [4:0] SLOT_BASE0 = 5'd4;
    localparam logic [4:0] SLOT_MASK0 = 5'd12;
    localparam logic [4:0] SLOT_BASE1 = 5'd16;
    localparam logic [4:0] SLOT_MASK1 = 5'd24;

    localparam logic [31:0] CS_BASE_BITS = 32'h1FF83FE0;
    localparam logic [31:0] CS_MASK_ONES = 32'h0007C01F;
    localparam logic [31:0] CS_MASK_KEEP = 32'h1FFFFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  reg_index;
        logic [31:0] reg_data;
        logic [47:0] phys_address;
    } t_item;

endpackage

// File: design/dard_in_if.sv
// Request channel: command beats into the decoder.
interface dard_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [8:0]  reg_index;
    logic [31:0] reg_data;
    logic [47:0] phys_address;

    modport source (output valid, command, reg_index, reg_data, phys_address, input ready);
    modport sink   (input valid, command, reg_index, reg_data, phys_address, output ready);
endinterface

// File: design/dard_out_if.sv
// Response channel: translation result beats out of the decoder.
interface dard_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [2:0] node;
    logic       channel;
    logic [2:0] chip_select;
    logic [2:0] dimm;
    logic       dimm_pair;

    modport source (output valid, found, node, channel, chip_select, dimm, dimm_pair,
                    input ready);
    modport sink   (input valid, found, node, channel, chip_select, dimm, dimm_pair,
                    output ready);
endinterface

// File: design/dram_address_to_rank_decoder_top.sv
// A table write is stored at the edge that takes it from the queue.
// Throughput: one beat at a time through the back-end sequencer, which walks the
// ranges and then the chip selects over the single read port of the node table.
// Reset: synchronous, active low; clears the queue, sequencer and spare-rank
// registers. The range and node tables are not cleared and must be written first.
module dram_address_to_rank_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dard_in_if.sink     i_req,
    dard_out_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [2:0]  i_cfg_data
);
    // Spare chip selects reported when a failed rank has been swapped out.
    logic [2:0] r_spare0;
    logic [2:0] r_spare1;

    // Queue between the front end and the sequencer.
    logic            q_valid;
    logic            q_pop;
    dard_pkg::t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spare0 <= 3'd0;
            r_spare1 <= 3'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == dard_pkg::CFG_SPARE_CHAN0) begin
                r_spare0 <= i_cfg_data;
            end
            if (i_cfg_idx == dard_pkg::CFG_SPARE_CHAN1) begin
                r_spare1 <= i_cfg_data;
            end
        end
    end

    // The front end takes a beat whenever its two-entry queue has room, so the
    // requester keeps moving while the sequencer works on an earlier beat.
    dard_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_pop     (q_pop),
        .o_q_valid (q_valid),
        .o_q_item  (q_item)
    );

    // The back end owns both tables, performs writes and runs the translation;
    // its output register lets it start the next beat while a result waits.
    dard_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (q_pop),
        .i_spare0  (r_spare0),
        .i_spare1  (r_spare1),
        .o_rsp     (o_rsp)
    );
endmodule

// File: design/dard_front.sv
// Front end: accepts request beats, classifies them and queues them.
`include "dram_address_to_rank_decoder_top_macros.svh"
module dard_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dard_in_if.sink           i_req,
    input  logic              i_pop,
    output logic              o_q_valid,
    output dard_pkg::t_item   o_q_item
);
    dard_pkg::t_item r_q [dard_pkg::QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    dard_pkg::t_item n_item;

    assign i_req.ready = (r_cnt != 2'(dard_pkg::QUEUE_DEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_item    = r_q[r_rp];

    always_comb begin
        n_item.reg_index    = i_req.reg_index;
        n_item.reg_data     = i_req.reg_data;
        n_item.phys_address = i_req.phys_address;
        if (i_req.command) begin
            n_item.kind = dard_pkg::KIND_XLATE;
        end else if (i_req.reg_index < 9'd32) begin
            n_item.kind = dard_pkg::KIND_RANGE_WR;
        end else if (i_req.reg_index < 9'd288) begin
            n_item.kind = dard_pkg::KIND_NODE_WR;
        end else begin
            n_item.kind = dard_pkg::KIND_DROP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    `DARD_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= 2'(dard_pkg::QUEUE_DEPTH), "queue overfilled")
    `DARD_ASSERT(a_pop_nonempty, i_clk, i_rst_n, !i_pop || (r_cnt != 2'd0), "pop from empty queue")
    `DARD_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, push && !i_pop && (r_cnt == 2'd1),
                      r_cnt == 2'd2, "queue count lost a push")
endmodule

// File: design/dard_back.sv
// Back end: table storage and the translation sequencer.
`include "dram_address_to_rank_decoder_top_macros.svh"
module dard_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  dard_pkg::t_item   i_q_item,
    output logic              o_pop,
    input  logic [2:0]        i_spare0,
    input  logic [2:0]        i_spare1,
    dard_out_if.source        o_rsp
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RRD   = 4'd1;
    localparam logic [3:0] S_RCHK  = 4'd2;
    localparam logic [3:0] S_NRD   = 4'd3;
    localparam logic [3:0] S_NCAP  = 4'd4;
    localparam logic [3:0] S_CALC  = 4'd5;
    localparam logic [3:0] S_SHIFT = 4'd6;
    localparam logic [3:0] S_CSB   = 4'd7;
    localparam logic [3:0] S_CSM   = 4'd8;
    localparam logic [3:0] S_CSC   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [31:0] r_blo [8];
    logic [31:0] r_llo [8];
    logic [31:0] r_bhi [8];
    logic [31:0] r_lhi [8];
    logic [31:0] r_node_mem [256];
    logic [31:0] r_blo_q, r_llo_q, r_bhi_q, r_lhi_q, r_nrd;

    logic [3:0]  r_st;
    logic [2:0]  r_r, r_k, r_nd, r_ien;
    logic [1:0]  r_slot, r_ilog;
    logic [47:0] r_addr, r_base, r_ca;
    logic [31:0] r_hole, r_dlo, r_dhi, r_sp, r_bw, r_inaddr;
    logic        r_ch, r_hisel, r_pf;
    logic [2:0]  r_pcs;
    logic        r_ov;
    logic        r_of, r_och, r_opair;
    logic [2:0]  r_onode, r_ocs, r_odimm;

    logic [7:0]  n_raddr;
    logic [4:0]  base_slot, mask_slot;
    logic        node_ok;
    logic [31:0] n_word;
    logic [47:0] rbase, rlimit;
    logic        rhit;
    logic [1:0]  n_ilog;
    logic        above4g, hisel, n_ch, par, il_en;
    logic [1:0]  il_addr;
    logic [47:0] hole_off, sel_off, off, n_ca, ca1, ca2;
    logic [31:0] cmask, cbase;
    logic        cs_hit, swap;
    logic [2:0]  bad, n_cs;
    logic        last_r, last_k, out_free;

    assign o_pop = (r_st == S_IDLE) && i_q_valid;

    // Table writes and registered reads of both tables.
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_q_item.kind == dard_pkg::KIND_RANGE_WR)) begin
            case (i_q_item.reg_index[1:0])
                2'd0:    r_blo[i_q_item.reg_index[4:2]] <= i_q_item.reg_data;
                2'd1:    r_llo[i_q_item.reg_index[4:2]] <= i_q_item.reg_data;
                2'd2:    r_bhi[i_q_item.reg_index[4:2]] <= i_q_item.reg_data;
                default: r_lhi[i_q_item.reg_index[4:2]] <= i_q_item.reg_data;
            endcase
        end
        if (o_pop && (i_q_item.kind == dard_pkg::KIND_NODE_WR)) begin
            r_node_mem[8'(i_q_item.reg_index - 9'd32)] <= i_q_item.reg_data;
        end
        r_blo_q <= r_blo[r_r];
        r_llo_q <= r_llo[r_r];
        r_bhi_q <= r_bhi[r_r];
        r_lhi_q <= r_lhi[r_r];
        r_nrd   <= r_node_mem[n_raddr];
    end

    assign base_slot = (r_ch ? dard_pkg::SLOT_BASE1 : dard_pkg::SLOT_BASE0) + 5'(r_k);
    assign mask_slot = (r_ch ? dard_pkg::SLOT_MASK1 : dard_pkg::SLOT_MASK0) + 5'(r_k[2:1]);

    always_comb begin
        case (r_st)
            S_NRD:   n_raddr = {r_nd, dard_pkg::SLOT_HOLE + 5'(r_slot)};
            S_CSB:   n_raddr = {r_nd, base_slot};
            S_CSM:   n_raddr = {r_nd, mask_slot};
            default: n_raddr = 8'd0;
        endcase
    end

    assign node_ok = ({1'b0, r_nd} < 4'(dard_pkg::NUM_NODES));
    assign n_word  = node_ok ? r_nrd : 32'd0;

    // Range check.
    assign rbase  = {r_bhi_q[7:0], r_blo_q[31:16], 24'h0};
    assign rlimit = {r_lhi_q[7:0], r_llo_q[31:16], 24'hFFFFFF};
    assign rhit   = (r_blo_q[1:0] != 2'd0) && (r_addr >= rbase) && (r_addr <= rlimit) &&
                    ((r_blo_q[10:8] == 3'd0) ||
                     (r_llo_q[10:8] == (r_addr[14:12] & r_blo_q[10:8])));
    always_comb begin
        case (r_blo_q[10:8])
            3'd1:    n_ilog = 2'd1;
            3'd3:    n_ilog = 2'd2;
            3'd7:    n_ilog = 2'd3;
            default: n_ilog = 2'd0;
        endcase
    end

    // Channel choice and offset removal.
    assign il_en    = r_dlo[2];
    assign il_addr  = r_dlo[7:6];
    assign above4g  = |r_addr[47:32];
    assign hisel    = r_dlo[0] && !r_dlo[4] && (r_addr[47:27] >= r_dlo[31:11]);
    assign par      = ^r_addr[20:16];
    assign hole_off = {16'h0, r_hole[15:7], 23'h0};
    assign sel_off  = {r_dhi[31:10], 26'h0};

    always_comb begin
        if (r_dlo[4]) begin
            n_ch = 1'b0;
        end else if (hisel) begin
            n_ch = r_dlo[1];
        end else if (il_en && (il_addr == 2'd0)) begin
            n_ch = r_addr[6];
        end else if (il_en && il_addr[1]) begin
            n_ch = (il_addr[0] ? r_addr[9] : r_addr[6]) ^ par;
        end else if (il_en && r_ien[2]) begin
            n_ch = r_addr[15];
        end else if (il_en && r_ien[1]) begin
            n_ch = r_addr[14];
        end else if (il_en && r_ien[0]) begin
            n_ch = r_addr[13];
        end else if (il_en) begin
            n_ch = r_addr[12];
        end else begin
            n_ch = r_dlo[0] && !r_dlo[1];
        end
        if (hisel) begin
            off = ((r_dlo[31:16] == 16'd0) && r_hole[0] && above4g) ? hole_off : sel_off;
        end else begin
            off = (r_hole[0] && above4g) ? hole_off : {r_base[47:27], 27'h0};
        end
        n_ca = {r_addr[47:6], 6'h0} - {off[47:23], 23'h0};
    end

    // Interleave bit removal.
    always_comb begin
        ca1 = ((r_ca >> r_ilog) & 48'hFFFFFFFFF000) | (r_ca & 48'hFC0);
        ca2 = ca1;
        if (r_dlo[2] && !r_hisel && !r_dlo[4]) begin
            if (!r_dlo[6]) begin
                ca2 = (ca1 >> 1) & ~48'h3F;
            end else if (r_dlo[7:6] == 2'd1) begin
                ca2 = ((ca1 & ~48'h1FFF) >> 1) | (ca1 & 48'hFC0);
            end else begin
                ca2 = ((ca1 & ~48'h3FF) >> 1) | (ca1 & 48'h1C0);
            end
        end
    end

    // Chip-select match and spare swap; r_nrd holds the mask word in S_CSC.
    assign cmask  = (n_word | dard_pkg::CS_MASK_ONES) & dard_pkg::CS_MASK_KEEP;
    assign cbase  = r_bw & dard_pkg::CS_BASE_BITS;
    assign cs_hit = r_bw[0] && ((r_inaddr & ~cmask) == (cbase & ~cmask));
    assign swap   = r_ch ? r_sp[3] : r_sp[1];
    assign bad    = r_ch ? r_sp[10:8] : r_sp[6:4];
    assign n_cs   = (swap && (r_k == bad)) ? (r_ch ? i_spare1 : i_spare0) : r_k;

    assign last_r   = (r_r == 3'(dard_pkg::NUM_RANGES - 1));
    assign last_k   = (r_k == 3'(dard_pkg::NUM_CHIP_SELECTS - 1));
    assign out_free = !r_ov || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_r  <= 3'd0;
        end else begin
            if ((r_st == S_OUT) && out_free) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (o_pop && (i_q_item.kind == dard_pkg::KIND_XLATE)) begin
                        r_addr <= i_q_item.phys_address;
                        r_r    <= 3'd0;
                        r_st   <= S_RRD;
                    end
                end
                S_RRD: begin
                    r_st <= S_RCHK;
                end
                S_RCHK: begin
                    if (rhit) begin
                        r_nd   <= r_llo_q[2:0];
                        r_ien  <= r_blo_q[10:8];
                        r_ilog <= n_ilog;
                        r_base <= rbase;
                        r_slot <= 2'd0;
                        r_st   <= S_NRD;
                    end else if (last_r) begin
                        r_pf <= 1'b0;
                        r_st <= S_OUT;
                    end else begin
                        r_r  <= r_r + 3'd1;
                        r_st <= S_RRD;
                    end
                end
                S_NRD: begin
                    r_st <= S_NCAP;
                end
                S_NCAP: begin
                    case (r_slot)
                        2'd0:    r_hole <= n_word;
                        2'd1:    r_dlo  <= n_word;
                        2'd2:    r_dhi  <= n_word;
                        default: r_sp   <= n_word;
                    endcase
                    r_slot <= r_slot + 2'd1;
                    r_st   <= (r_slot == 2'd3) ? S_CALC : S_NRD;
                end
                S_CALC: begin
                    r_ch    <= n_ch;
                    r_hisel <= hisel;
                    r_ca    <= n_ca;
                    r_st    <= S_SHIFT;
                end
                S_SHIFT: begin
                    r_inaddr <= ca2[39:8];
                    r_k      <= 3'd0;
                    r_st     <= S_CSB;
                end
                S_CSB: begin
                    r_st <= S_CSM;
                end
                S_CSM: begin
                    r_bw <= n_word;
                    r_st <= S_CSC;
                end
                S_CSC: begin
                    if (cs_hit) begin
                        r_pf  <= 1'b1;
                        r_pcs <= n_cs;
                        r_st  <= S_OUT;
                    end else if (!last_k) begin
                        r_k  <= r_k + 3'd1;
                        r_st <= S_CSB;
                    end else if (last_r) begin
                        r_pf <= 1'b0;
                        r_st <= S_OUT;
                    end else begin
                        r_r  <= r_r + 3'd1;
                        r_st <= S_RRD;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_of    <= r_pf;
                        r_onode <= r_pf ? r_nd : 3'd0;
                        r_och   <= r_pf && r_ch;
                        r_ocs   <= r_pf ? r_pcs : 3'd0;
                        r_odimm <= r_pf ? {r_pcs[2:1], r_ch && !r_dlo[4]} : 3'd0;
                        r_opair <= r_pf && r_dlo[4];
                        r_st    <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.found       = r_of;
    assign o_rsp.node        = r_onode;
    assign o_rsp.channel     = r_och;
    assign o_rsp.chip_select = r_ocs;
    assign o_rsp.dimm        = r_odimm;
    assign o_rsp.dimm_pair   = r_opair;

    `DARD_ASSERT(a_miss_zero, i_clk, i_rst_n,
                 !r_ov || r_of || ((r_onode == 3'd0) && !r_och && (r_ocs == 3'd0) &&
                                   (r_odimm == 3'd0) && !r_opair),
                 "miss beat carries nonzero fields")
    `DARD_ASSERT(a_load_from_out, i_clk, i_rst_n,
                 !$rose(r_ov) || ($past(r_st) == S_OUT), "result loaded outside output step")
    `DARD_ASSERT(a_pop_idle, i_clk, i_rst_n, !o_pop || (r_st == S_IDLE),
                 "queue popped while busy")
endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the DRAM address to rank decoder top level.
`timescale 1ns / 1ps

module tb_top;

    // Command codes of a request beat.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_XLATE = 1'b1;

    // Node table slots that the package does not name.
    localparam logic [4:0] SLOT_DCT_LO = 5'd1;
    localparam logic [4:0] SLOT_DCT_HI = 5'd2;
    localparam logic [4:0] SLOT_SPARE  = 5'd3;

    localparam int TABLE_WORDS  = 288;
    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 800;

    typedef struct packed {
        logic       found;
        logic [2:0] node;
        logic       channel;
        logic [2:0] chip_select;
        logic [2:0] dimm;
        logic       dimm_pair;
    } t_rank_result;

    // Shadow tables, spare-rank settings and the queue of pending rank results.
    class t_rank_decode_scoreboard;
        logic [31:0]  range_w[32];
        logic [31:0]  node_w[256];
        logic [2:0]   spare0;
        logic [2:0]   spare1;
        t_rank_result pending_q[$];
        int           errors;
        int           n_writes;
        int           n_xlates;
        int           n_found;
        int           n_swapped;

        function new();
            spare0 = '0;
            spare1 = '0;
            errors = 0;
            n_writes = 0;
            n_xlates = 0;
            n_found = 0;
            n_swapped = 0;
        endfunction

        function logic [31:0] nword(logic [2:0] nd, logic [4:0] slot);
            return node_w[{nd, slot}];
        endfunction

        // Walks the ranges in order and returns the rank that the address maps to.
        function t_rank_result decode(logic [47:0] addr);
            t_rank_result res;
            logic [31:0] blo, llo, bhi, lhi, hole, dlo, dhi, bw, mw, cbase, cmask, sp;
            logic [31:0] in_addr;
            logic [47:0] base, limit;
            logic [63:0] off, sel_off, ca, t;
            logic [2:0]  ien, isel, nd, bad, cs;
            logic [1:0]  il_addr;
            logic        hole_en, hi_en, sel_hi, il_en, gang, hi_sel, ch, swap, par;
            int          ilog;
            res = '0;
            for (int r = 0; r < dard_pkg::NUM_RANGES && !res.found; r++) begin
                blo = range_w[r * 4];
                llo = range_w[r * 4 + 1];
                bhi = range_w[r * 4 + 2];
                lhi = range_w[r * 4 + 3];
                ien = blo[10:8];
                isel = llo[10:8];
                nd = llo[2:0];
                base = {bhi[7:0], blo[31:16], 24'h0};
                limit = {lhi[7:0], llo[31:16], 24'hFFFFFF};
                if (blo[1:0] == 2'b00 || addr < base || addr > limit) continue;
                if (ien != 3'd0 && isel != (addr[14:12] & ien)) continue;
                ilog = (ien == 3'd1) ? 1 : (ien == 3'd3) ? 2 : (ien == 3'd7) ? 3 : 0;
                hole = nword(nd, dard_pkg::SLOT_HOLE);
                hole_en = hole[0];
                dlo = nword(nd, SLOT_DCT_LO);
                dhi = nword(nd, SLOT_DCT_HI);
                hi_en = dlo[0];
                sel_hi = dlo[1];
                il_en = dlo[2];
                gang = dlo[4];
                il_addr = dlo[7:6];
                sel_off = {32'h0, dhi & 32'hFFFFFC00} << 16;
                hi_sel = hi_en && !gang && (addr[47:27] >= dlo[31:11]);
                par = ^addr[20:16];
                if (gang) ch = 1'b0;
                else if (hi_sel) ch = sel_hi;
                else if (il_en && il_addr == 2'd0) ch = addr[6];
                else if (il_en && il_addr[1]) ch = (il_addr[0] ? addr[9] : addr[6]) ^ par;
                else if (il_en && ien[2]) ch = addr[15];
                else if (il_en && ien[1]) ch = addr[14];
                else if (il_en && ien[0]) ch = addr[13];
                else if (il_en) ch = addr[12];
                else if (hi_en) ch = ~sel_hi;
                else ch = 1'b0;
                // The hole offset applies above 4 GB; otherwise the select or range base.
                if (hi_sel) begin
                    if (dlo[31:16] == 16'h0 && hole_en && addr[47:32] != 16'h0)
                        off = {48'h0, hole[15:7], 7'h0} << 16;
                    else
                        off = sel_off;
                end else begin
                    if (hole_en && addr[47:32] != 16'h0)
                        off = {48'h0, hole[15:7], 7'h0} << 16;
                    else
                        off = {16'h0, base} & 64'hFFFFF8000000;
                end
                ca = (({16'h0, addr} & 64'hFFFFFFFFFFC0) - (off & 64'hFFFFFF800000))
                     & 64'hFFFFFFFFFFFF;
                t = ca & 64'hFC0;
                ca = ((ca >> ilog) & 64'hFFFFFFFFF000) | t;
                if (il_en && !hi_sel && !gang) begin
                    if (!il_addr[0]) begin
                        ca = (ca >> 1) & ~64'h3F;
                    end else if (il_addr == 2'd1) begin
                        t = ca & 64'hFC0;
                        ca = ((ca & ~64'h1FFF) >> 1) | t;
                    end else begin
                        t = ca & 64'h1C0;
                        ca = ((ca & ~64'h3FF) >> 1) | t;
                    end
                end
                in_addr = ca[39:8];
                for (int k = 0; k < dard_pkg::NUM_CHIP_SELECTS; k++) begin
                    bw = nword(nd, (ch ? dard_pkg::SLOT_BASE1 : dard_pkg::SLOT_BASE0) + 5'(k));
                    mw = nword(nd, (ch ? dard_pkg::SLOT_MASK1 : dard_pkg::SLOT_MASK0)
                                   + 5'(k >> 1));
                    cbase = bw & dard_pkg::CS_BASE_BITS;
                    cmask = (mw | dard_pkg::CS_MASK_ONES) & dard_pkg::CS_MASK_KEEP;
                    if (bw[0] && ((in_addr & ~cmask) == (cbase & ~cmask))) begin
                        sp = nword(nd, SLOT_SPARE);
                        swap = ch ? sp[3] : sp[1];
                        bad = ch ? sp[10:8] : sp[6:4];
                        cs = 3'(k);
                        if (swap && cs == bad) cs = ch ? spare1 : spare0;
                        res.found = 1'b1;
                        res.node = nd;
                        res.channel = ch;
                        res.chip_select = cs;
                        break;
                    end
                end
            end
            if (res.found) begin
                dlo = nword(res.node, SLOT_DCT_LO);
                gang = dlo[4];
                res.dimm = {res.chip_select[2:1], 1'b0} + (gang ? 3'd0 : {2'b0, res.channel});
                res.dimm_pair = gang;
            end
            return res;
        endfunction

        function void note_beat(logic cmd, logic [8:0] idx, logic [31:0] data,
                                logic [47:0] addr);
            if (cmd == CMD_WRITE) begin
                n_writes++;
                if (idx < 9'd32) range_w[idx[4:0]] = data;
                else if (idx < 9'(TABLE_WORDS)) node_w[8'(idx - 9'd32)] = data;
            end else begin
                n_xlates++;
                pending_q.push_back(decode(addr));
            end
        endfunction

        function void report(string field, logic [2:0] want, logic [2:0] got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_beat(t_rank_result got);
            t_rank_result want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (want.found) n_found++;
            if (got.found !== want.found) report("found", want.found, got.found);
            if (got.node !== want.node) report("node", want.node, got.node);
            if (got.channel !== want.channel) report("channel", want.channel, got.channel);
            if (got.chip_select !== want.chip_select)
                report("chip_select", want.chip_select, got.chip_select);
            if (got.dimm !== want.dimm) report("dimm", want.dimm, got.dimm);
            if (got.dimm_pair !== want.dimm_pair)
                report("dimm_pair", want.dimm_pair, got.dimm_pair);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [2:0]  i_cfg_data;

    dard_in_if  req();
    dard_out_if rsp();

    dram_address_to_rank_decoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_rsp      (rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_rank_decode_scoreboard rank_sb = new();

    // Sender burst state, receiver hold-off request and stall pattern.
    int burst_left = 0;
    bit steady_send = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int idle_cycles = 0;

    // Receiver: checks each accepted result beat, then decides the next ready.
    // The stall pattern is drawn at random between always-ready, light and
    // heavy back-pressure; a hold-off request forces ready low for a long stretch.
    initial begin : receiver
        int cyc;
        cyc = 0;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp.valid && rsp.ready)
                rank_sb.check_beat({rsp.found, rsp.node, rsp.channel, rsp.chip_select,
                                    rsp.dimm, rsp.dimm_pair});
            cyc++;
            if (cyc % 256 == 0) stall_mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left--;
                rsp.ready <= 1'b0;
            end else if (stall_mode == 0) begin
                rsp.ready <= 1'b1;
            end else if (stall_mode == 1) begin
                rsp.ready <= ($urandom_range(0, 3) != 0);
            end else begin
                rsp.ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("dram_address_to_rank_decoder_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one request beat and waits for it to be taken. Bursts of random
    // length are separated by random gaps, except in steady stretches.
    task automatic send_beat(logic cmd, logic [8:0] idx, logic [31:0] data,
                             logic [47:0] addr);
        int gap;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        req.valid <= 1'b1;
        req.command <= cmd;
        req.reg_index <= idx;
        req.reg_data <= data;
        req.phys_address <= addr;
        do @(posedge i_clk); while (!req.ready);
        rank_sb.note_beat(cmd, idx, data, addr);
        burst_left--;
        if (burst_left == 0) begin
            gap = steady_send ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_word(logic [8:0] idx, logic [31:0] data);
        send_beat(CMD_WRITE, idx, data, 48'({$urandom, $urandom}));
    endtask

    task automatic translate(logic [47:0] addr);
        send_beat(CMD_XLATE, 9'($urandom), $urandom, addr);
    endtask

    // Plausible contents for one table word, so that translations reach the
    // chip-select compare and often hit.
    function automatic logic [31:0] shaped_word(int idx);
        logic [31:0] w;
        int r, slot;
        w = $urandom;
        if (idx < 32) begin
            r = idx / 4;
            case (idx % 4)
                0: begin
                    w[31:16] = 16'(r * 16'h0100 + $urandom_range(0, 16'h00C0));
                    w[10:8] = ($urandom_range(0, 3) == 0) ? 3'(($urandom_range(0, 2) == 0) ?
                              1 : ($urandom_range(0, 1) ? 3 : 7)) : 3'd0;
                    w[1:0] = ($urandom_range(0, 5) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
                end
                1: begin
                    w[31:16] = 16'(r * 16'h0100 + $urandom_range(16'h00C0, 16'h01FF));
                    w[2:0] = ($urandom_range(0, 1) == 0) ? 3'(r) : 3'($urandom);
                end
                default: w = ($urandom_range(0, 7) == 0) ? {24'h0, 8'($urandom)} : 32'h0;
            endcase
        end else begin
            slot = (idx - 32) % 32;
            if (slot >= 4 && slot < 12 || slot >= 16 && slot < 24) begin
                w[0] = ($urandom_range(0, 4) != 0);
            end else if (slot >= 12 && slot < 16 || slot >= 24 && slot < 28) begin
                if ($urandom_range(0, 2) != 0) w = w | dard_pkg::CS_MASK_KEEP;
            end else if (slot == 1) begin
                w[31:16] = ($urandom_range(0, 1) == 0) ? 16'h0 : w[31:16];
            end
        end
        return w;
    endfunction

    // Picks an address inside a random range most of the time, else anywhere.
    function automatic logic [47:0] pick_address();
        logic [47:0] lo, hi, span;
        int r;
        if ($urandom_range(0, 9) == 0) return 48'({$urandom, $urandom});
        r = $urandom_range(0, dard_pkg::NUM_RANGES - 1);
        lo = {rank_sb.range_w[r * 4 + 2][7:0], rank_sb.range_w[r * 4][31:16], 24'h0};
        hi = {rank_sb.range_w[r * 4 + 3][7:0], rank_sb.range_w[r * 4 + 1][31:16], 24'hFFFFFF};
        if (hi < lo) return lo;
        span = hi - lo;
        return 48'(lo + ({$urandom, $urandom} % (span + 48'd1)));
    endfunction

    // Waits for every result, lets trailing writes retire, then sets spares.
    task automatic set_spares(logic [2:0] chan0, logic [2:0] chan1);
        req.valid <= 1'b0;
        while (rank_sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= dard_pkg::CFG_SPARE_CHAN0;
        i_cfg_data <= chan0;
        @(posedge i_clk);
        i_cfg_idx <= dard_pkg::CFG_SPARE_CHAN1;
        i_cfg_data <= chan1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rank_sb.spare0 = chan0;
        rank_sb.spare1 = chan1;
    endtask

    initial begin : stimulus
        int idx;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= dard_pkg::CFG_SPARE_CHAN0;
        i_cfg_data <= '0;
        req.valid <= 1'b0;
        req.command <= CMD_WRITE;
        req.reg_index <= '0;
        req.reg_data <= '0;
        req.phys_address <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_spares(3'd7, 3'd0);

        // Every table word is written first, since the tables power up unknown.
        for (int i = 0; i < TABLE_WORDS; i++) write_word(9'(i), shaped_word(i));

        // Directed: address extremes, a miss, ignored writes past the tables,
        // a full-ones data word, and an all-matching ganged node.
        translate(48'h0);
        translate(48'hFFFF_FFFF_FFFF);
        translate(48'h8000_0000_0000);
        write_word(9'd288, 32'hFFFF_FFFF);
        write_word(9'h1FF, 32'hA5A5_5A5A);
        write_word(9'd287, 32'hFFFF_FFFF);
        write_word(9'd0, 32'h0000_0003);
        write_word(9'd1, 32'hFFFF_0000);
        write_word(9'd2, 32'h0);
        write_word(9'd3, 32'h0);
        write_word(9'(32 + SLOT_DCT_LO), 32'h0000_0010);
        write_word(9'(32 + SLOT_SPARE), 32'h0000_0002);
        write_word(9'(32 + dard_pkg::SLOT_BASE0), 32'h0000_0001);
        write_word(9'(32 + dard_pkg::SLOT_MASK0), 32'hFFFF_FFFF);
        translate(48'h0000_0000_1234);
        translate(48'h00FF_FFFF_FFFF);
        translate(48'h0100_0000_0000);
        write_word(9'(32 + SLOT_DCT_LO), 32'h0000_00C4);
        write_word(9'(32 + dard_pkg::SLOT_HOLE), 32'h0000_FF81);
        translate(48'h0001_0000_0040);
        translate(48'h0000_FFFF_FFC0);

        // Random phases with different spare settings; one phase runs with a
        // long receiver hold-off so the request queue backs up.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_spares(3'd0, 3'd0);
                1: set_spares(3'd7, 3'd7);
                2: set_spares(3'd0, 3'd7);
                default: set_spares(3'($urandom), 3'($urandom));
            endcase
            steady_send = (phase == 1);
            if (phase == 2) hold_left = HOLD_CYCLES;
            for (int n = 0; n < 260; n++) begin
                if ($urandom_range(0, 5) == 0) begin
                    idx = $urandom_range(0, TABLE_WORDS - 1);
                    write_word(9'(idx), ($urandom_range(0, 9) == 0) ? $urandom
                                                                    : shaped_word(idx));
                end else if ($urandom_range(0, 60) == 0) begin
                    write_word(9'($urandom_range(TABLE_WORDS, 511)), $urandom);
                end else begin
                    translate(pick_address());
                end
            end
        end
        req.valid <= 1'b0;

        while (rank_sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d table writes and %0d translations, %0d of them hit a rank.",
                 rank_sb.n_writes, rank_sb.n_xlates, rank_sb.n_found);
        if (rank_sb.errors == 0 && rank_sb.pending_q.size() == 0) begin
            $display("dram_address_to_rank_decoder_top verification clean");
        end else begin
            $display("dram_address_to_rank_decoder_top verification failed");
        end
        $finish;
    end

endmodule
